### rtl/frc_pkg.sv
// frc_pkg: types, constants and small helper functions for the framed reply checker
// used by framed_reply_checker and frc_checker; no other dependencies
`default_nettype none

package frc_pkg;

    localparam int MAX_FRAME_CHARS = 4;
    localparam int WIN_DEPTH       = MAX_FRAME_CHARS + 4;
    localparam int MAX_REPLY_CHARS = 255;
    localparam int POS_W           = 8;
    localparam int CFG_IDX_W       = 3;

    localparam logic [15:0] CKS_SEED = 16'h5A5A;

    typedef enum logic [2:0] {
        VERDICT_OK        = 3'd0,
        VERDICT_BAD_FRAME = 3'd1,
        VERDICT_BAD_CKS   = 3'd2,
        VERDICT_NO_ID     = 3'd3,
        VERDICT_WRONG_ID  = 3'd4,
        VERDICT_NO_STATUS = 3'd5
    } t_verdict;

    typedef enum logic {
        CMD_BEGIN = 1'b0,
        CMD_CHAR  = 1'b1
    } t_command;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHECK_CRC   = 3'd0,
        CFG_START_CHARS = 3'd1,
        CFG_START_LEN   = 3'd2,
        CFG_END_CHARS   = 3'd3,
        CFG_END_LEN     = 3'd4
    } t_cfg_index;

    // entry 0 is the most recent earlier character
    typedef logic [WIN_DEPTH-1:0][7:0] t_window;

    function automatic logic [2:0] clamp_len(input logic [2:0] n);
        return (n > 3'(MAX_FRAME_CHARS)) ? 3'(MAX_FRAME_CHARS) : n;
    endfunction

    function automatic logic [7:0] frame_byte(input logic [31:0] chars, input logic [1:0] i);
        return chars[8*i +: 8];
    endfunction

    // bit 4 set means not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] h;
        h = 5'd16;
        if (c >= "0" && c <= "9") begin
            h = 5'(c - 8'h30);
        end else if (c >= "A" && c <= "F") begin
            h = 5'(c - 8'h37);
        end else if (c >= "a" && c <= "f") begin
            h = 5'(c - 8'h57);
        end
        return h;
    endfunction

    function automatic logic [15:0] checksum_step(input logic [15:0] s, input logic [7:0] b);
        logic [15:0] v;
        v = s ^ {8'h00, b};
        v = {v[8:0], v[15:9]};
        return v ^ {8'h00, b};
    endfunction

    // character j places back, j = 0 is the current one
    function automatic logic [7:0] back_char(input logic [3:0] j, input logic [7:0] c,
                                             input t_window w);
        logic [3:0] jm;
        jm = j - 4'd1;
        return (j == 4'd0) ? c : w[jm[2:0]];
    endfunction

endpackage

`default_nettype wire

### rtl/framed_reply_checker.sv
// framed_reply_checker: checks framing, checksum, id and status of one ascii reply
// depends on frc_pkg
//
//   channel   direction  handshake               payload
//   in        sink       i_in_valid/o_in_stall   command, expected_id, has_status,
//                                                reply_char, last_char
//   out       source     o_out_valid/i_out_stall verdict, reply_id, status_value,
//                                                status_error
//   cfg       sink       i_cfg_valid/o_cfg_ready index (3 bits), data (32 bits)
//
// one beat per cycle sustained while the input register does not hold; a beat is first
// registered in the input register, and the per-reply state and the result register
// update on the edge that moves it on, so a verdict passes the input and result registers.
// the input register only holds when a verdict is pending and the result register is
// full and stalled. reset is synchronous; it restores reply state, config and valid flags.
`default_nettype none

module framed_reply_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_command,
    input  wire logic [7:0]                  i_expected_id,
    input  wire logic                        i_has_status,
    input  wire logic [7:0]                  i_reply_char,
    input  wire logic                        i_last_char,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [2:0]                       o_verdict,
    output logic [7:0]                       o_reply_id,
    output logic [9:0]                       o_status_value,
    output logic                             o_status_error,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [frc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                 i_cfg_data
);
    import frc_pkg::*;

    // configuration
    logic        r_check_crc;
    logic [31:0] r_start_chars;
    logic [2:0]  r_start_len;
    logic [31:0] r_end_chars;
    logic [2:0]  r_end_len;

    // input register
    logic        r_in_valid;
    t_command    r_in_cmd;
    logic [7:0]  r_in_id;
    logic        r_in_has_status;
    logic [7:0]  r_in_char;
    logic        r_in_last;

    // reply state
    t_window           r_window,     n_window;
    logic [15:0]       r_cks,        n_cks;
    logic [POS_W-1:0]  r_pos,        n_pos;
    logic              r_start_ok,   n_start_ok;
    logic              r_overlong,   n_overlong;
    logic [7:0]        r_awaited,    n_awaited;
    logic              r_stat_exp,   n_stat_exp;
    logic [7:0]        r_pid,        n_pid;
    logic [1:0]        r_idv,        n_idv;
    logic [9:0]        r_sacc,       n_sacc;
    logic [1:0]        r_sdv,        n_sdv;

    // result register
    logic              r_out_valid;
    t_verdict          r_verdict,    n_verdict;
    logic [7:0]        r_rid,        n_rid;
    logic [9:0]        r_sval,       n_sval;

    logic produces;
    logic advance;
    logic in_take;

    assign produces    = (r_in_cmd == CMD_CHAR) && r_in_last;
    assign advance     = r_in_valid && (!produces || !r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_crc   <= 1'b0;
            r_start_chars <= '0;
            r_start_len   <= '0;
            r_end_chars   <= '0;
            r_end_len     <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_CHECK_CRC:   r_check_crc   <= i_cfg_data[0];
                CFG_START_CHARS: r_start_chars <= i_cfg_data;
                CFG_START_LEN:   r_start_len   <= i_cfg_data[2:0];
                CFG_END_CHARS:   r_end_chars   <= i_cfg_data;
                CFG_END_LEN:     r_end_len     <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_cmd        <= t_command'(i_command);
            r_in_id         <= i_expected_id;
            r_in_has_status <= i_has_status;
            r_in_char       <= i_reply_char;
            r_in_last       <= i_last_char;
        end
    end

    always_comb begin
        logic [2:0]       sl;
        logic [2:0]       el;
        logic [3:0]       k;
        logic [7:0]       c;
        logic [7:0]       dch;
        logic [POS_W-1:0] d;
        logic [4:0]       h;
        logic [8:0]       total;
        logic [8:0]       body;
        logic [15:0]      given;
        logic             digits_ok;
        logic             frame_bad;
        logic [2:0]       bi;
        logic [4:0]       hd;
        t_verdict         v;

        n_window   = r_window;
        n_cks      = r_cks;
        n_pos      = r_pos;
        n_start_ok = r_start_ok;
        n_overlong = r_overlong;
        n_awaited  = r_awaited;
        n_stat_exp = r_stat_exp;
        n_pid      = r_pid;
        n_idv      = r_idv;
        n_sacc     = r_sacc;
        n_sdv      = r_sdv;
        n_verdict  = VERDICT_OK;
        n_rid      = '0;
        n_sval     = '0;

        sl    = clamp_len(r_start_len);
        el    = clamp_len(r_end_len);
        k     = {1'b0, el} + (r_check_crc ? 4'd4 : 4'd0);
        c     = r_in_char;
        dch   = back_char(k, c, r_window);
        d     = r_pos - POS_W'(k) - POS_W'(sl);
        h     = hex_value(dch);
        total = {1'b0, r_pos} + 9'd1;
        body  = total - 9'(sl) - 9'(el);
        given = '0;
        digits_ok = 1'b1;
        frame_bad = 1'b0;
        bi    = '0;
        hd    = '0;
        v     = VERDICT_OK;

        if (r_in_cmd == CMD_BEGIN) begin
            n_awaited  = r_in_id;
            n_stat_exp = r_in_has_status;
        end else begin
            if (!r_overlong) begin
                if (r_pos < POS_W'(sl) && c != frame_byte(r_start_chars, r_pos[1:0])) begin
                    n_start_ok = 1'b0;
                end
                // characters after the start frame and before checksum and end frame feed checksum, id and status
                if ({1'b0, r_pos} >= 9'(k) + 9'(sl)) begin
                    n_cks = checksum_step(r_cks, dch);
                    if (d == POS_W'(0) && !h[4]) begin
                        n_pid = {4'h0, h[3:0]};
                        n_idv = 2'd1;
                    end else if (d == POS_W'(1) && !h[4] && r_idv == 2'd1) begin
                        n_pid = {r_pid[3:0], h[3:0]};
                        n_idv = 2'd2;
                    end else if (d >= POS_W'(5) && d <= POS_W'(7) && dch >= "0" && dch <= "9"
                                 && r_sdv == 2'(d - POS_W'(5))) begin
                        n_sacc = 10'(r_sacc * 10'd10) + 10'(dch - 8'h30);
                        n_sdv  = 2'(d - POS_W'(4));
                    end
                end
            end

            if (!r_in_last) begin
                n_window = {r_window[WIN_DEPTH-2:0], c};
                if (total >= 9'(MAX_REPLY_CHARS)) begin
                    n_overlong = 1'b1;
                end else begin
                    n_pos = total[POS_W-1:0];
                end
            end else begin
                for (int i = 0; i < MAX_FRAME_CHARS; i++) begin
                    bi = el - 3'(i) - 3'd1;
                    if (3'(i) < el &&
                        back_char({1'b0, bi}, c, r_window) != frame_byte(r_end_chars, 2'(i))) begin
                        frame_bad = 1'b1;
                    end
                end
                for (int t = 0; t < 4; t++) begin
                    hd = hex_value(back_char({1'b0, el} + 4'(3 - t), c, r_window));
                    if (hd[4]) begin
                        digits_ok = 1'b0;
                    end
                    given[15-4*t -: 4] = hd[3:0];
                end

                if (r_overlong || !n_start_ok || total <= 9'(sl) + 9'(el) || frame_bad) begin
                    v = VERDICT_BAD_FRAME;
                end else if (r_check_crc &&
                             (body < 9'd4 || !digits_ok || given != n_cks)) begin
                    v = VERDICT_BAD_CKS;
                end else if (n_idv != 2'd2) begin
                    v = VERDICT_NO_ID;
                end else if (n_pid != r_awaited) begin
                    v = VERDICT_WRONG_ID;
                end else if (r_stat_exp && n_sdv != 2'd3) begin
                    v = VERDICT_NO_STATUS;
                end
                n_verdict = v;
                if (v == VERDICT_OK || v == VERDICT_WRONG_ID || v == VERDICT_NO_STATUS) begin
                    n_rid = n_pid;
                end
                if (v == VERDICT_OK && r_stat_exp) begin
                    n_sval = n_sacc;
                end
            end
        end

        // a begin or a verdict starts a fresh reply
        if (r_in_cmd == CMD_BEGIN || r_in_last) begin
            n_window   = '0;
            n_cks      = CKS_SEED;
            n_pos      = '0;
            n_start_ok = 1'b1;
            n_overlong = 1'b0;
            n_pid      = '0;
            n_idv      = '0;
            n_sacc     = '0;
            n_sdv      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= '0;
            r_cks      <= CKS_SEED;
            r_pos      <= '0;
            r_start_ok <= 1'b1;
            r_overlong <= 1'b0;
            r_awaited  <= '0;
            r_stat_exp <= 1'b0;
            r_pid      <= '0;
            r_idv      <= '0;
            r_sacc     <= '0;
            r_sdv      <= '0;
        end else if (advance) begin
            r_window   <= n_window;
            r_cks      <= n_cks;
            r_pos      <= n_pos;
            r_start_ok <= n_start_ok;
            r_overlong <= n_overlong;
            r_awaited  <= n_awaited;
            r_stat_exp <= n_stat_exp;
            r_pid      <= n_pid;
            r_idv      <= n_idv;
            r_sacc     <= n_sacc;
            r_sdv      <= n_sdv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && produces) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && produces) begin
            r_verdict <= n_verdict;
            r_rid     <= n_rid;
            r_sval    <= n_sval;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_verdict      = r_verdict;
    assign o_reply_id     = r_rid;
    assign o_status_value = r_sval;
    assign o_status_error = (r_verdict == VERDICT_OK) && (r_sval != 10'd0);

endmodule

`default_nettype wire

### rtl/frc_checker.sv
// frc_checker: port level assertions for the framed reply checker, bound to the top level
// depends on frc_pkg and framed_reply_checker
`default_nettype none

module frc_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic [2:0]                  o_verdict,
    input wire logic [7:0]                  o_reply_id,
    input wire logic [9:0]                  o_status_value,
    input wire logic                        o_status_error
);
    import frc_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_verdict)
            && $stable(o_reply_id) && $stable(o_status_value))
        else $error("result beat changed while stalled");

    a_status_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status_error |-> o_verdict == VERDICT_OK && o_status_value != 10'd0)
        else $error("status error without ok verdict");

    a_no_status_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_verdict != VERDICT_OK |-> o_status_value == 10'd0)
        else $error("status value on failed reply");

    a_no_id_on_frame_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_verdict == VERDICT_BAD_FRAME || o_verdict == VERDICT_BAD_CKS
            || o_verdict == VERDICT_NO_ID) |-> o_reply_id == 8'd0)
        else $error("reply id reported for reply without a valid id");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status_value <= 10'd999)
        else $error("status value above three digits");

endmodule

bind framed_reply_checker frc_checker u_frc_checker (.*);

`default_nettype wire

### sim/tb_framed_reply_checker.sv
// tb_framed_reply_checker: self-checking bench for framed_reply_checker, a directed table
// then framed replies with random content, random sender gaps and receiver stalls
// depends on frc_pkg and rtl/framed_reply_checker.sv
module tb_framed_reply_checker;
    timeunit 1ns;
    timeprecision 1ps;

    import frc_pkg::*;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_BEATS   = 1000;
    localparam int SETTLE_CYCLES  = 4;

    typedef struct {
        t_command   cmd;
        logic [7:0] eid;
        logic       hs;
        logic [7:0] ch;
        logic       last;
    } t_beat;

    typedef struct {
        t_verdict   verdict;
        logic [7:0] rid;
        logic [9:0] sval;
        logic       err;
    } t_reply_result;

    typedef enum {ROW_BEAT, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind     kind;
        t_beat         b;
        t_cfg_index    idx;
        logic [31:0]   data;
        bit            fixed;
        t_reply_result r;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    logic i_command;
    logic [7:0] i_expected_id;
    logic i_has_status;
    logic [7:0] i_reply_char;
    logic i_last_char;
    logic o_out_valid;
    logic i_out_stall;
    logic [2:0] o_verdict;
    logic [7:0] o_reply_id;
    logic [9:0] o_status_value;
    logic o_status_error;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    framed_reply_checker i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_expected_id  (i_expected_id),
        .i_has_status   (i_has_status),
        .i_reply_char   (i_reply_char),
        .i_last_char    (i_last_char),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_verdict      (o_verdict),
        .o_reply_id     (o_reply_id),
        .o_status_value (o_status_value),
        .o_status_error (o_status_error),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // register copies
    logic        crc_on_cfg;
    logic [31:0] sframe_chars;
    logic [2:0]  sframe_len;
    logic [31:0] eframe_chars;
    logic [2:0]  eframe_len;

    // per-reply state of the predictor
    logic [7:0]  win [WIN_DEPTH];
    logic [15:0] run_cks;
    int          char_pos;
    bit          sframe_ok;
    bit          too_long;
    logic [7:0]  want_id;
    bit          want_status;
    logic [7:0]  got_id;
    int          id_digits;
    int          stat_acc;
    int          stat_digits;

    t_reply_result verdicts_due[$];
    t_stim_row     script[$];
    int            mismatches;
    int            beats_sent;
    int            burst_left;
    int            long_replies;
    bit            hold_req;

    task automatic flag_error(input string what);
        if (mismatches < 100) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
        mismatches++;
    endtask

    function automatic int eff_len(input logic [2:0] n);
        return (n > MAX_FRAME_CHARS) ? MAX_FRAME_CHARS : int'(n);
    endfunction

    function automatic int hex_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
        if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
        if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
        return 16;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [15:0] mix16(input logic [15:0] s, input logic [7:0] c);
        logic [15:0] v;
        v = s ^ 16'(c);
        v = (v << 7) | (v >> 9);
        return v ^ 16'(c);
    endfunction

    // j characters back from the current one
    function automatic logic [7:0] win_char(input int j, input logic [7:0] c);
        return (j == 0) ? c : win[j - 1];
    endfunction

    function automatic void clear_reply();
        foreach (win[i]) win[i] = 8'h00;
        run_cks     = CKS_SEED;
        char_pos    = 0;
        sframe_ok   = 1'b1;
        too_long    = 1'b0;
        got_id      = 8'h00;
        id_digits   = 0;
        stat_acc    = 0;
        stat_digits = 0;
    endfunction

    function automatic void take_data(input int d, input logic [7:0] c);
        int h;
        run_cks = mix16(run_cks, c);
        h = hex_of(c);
        if (d == 0 && h < 16) begin
            got_id    = 8'(h);
            id_digits = 1;
        end else if (d == 1 && h < 16 && id_digits == 1) begin
            got_id    = {got_id[3:0], 4'(h)};
            id_digits = 2;
        end else if (d >= 5 && d <= 7 && c >= 8'h30 && c <= 8'h39 && stat_digits == d - 5) begin
            stat_acc    = stat_acc * 10 + (c - 8'h30);
            stat_digits = d - 4;
        end
    endfunction

    // returns 1 when the beat closes a reply
    function automatic bit judge_beat(input t_beat b, output t_reply_result r);
        int sl, el, k, pos, total, i, j, h;
        logic [7:0] c;
        logic [15:0] given;
        bit digits_ok;
        r = '{VERDICT_OK, 8'h00, 10'd0, 1'b0};
        if (b.cmd == CMD_BEGIN) begin
            want_id     = b.eid;
            want_status = b.hs;
            clear_reply();
            return 1'b0;
        end
        c   = b.ch;
        sl  = eff_len(sframe_len);
        el  = eff_len(eframe_len);
        k   = el + (crc_on_cfg ? 4 : 0);
        pos = char_pos;
        if (!too_long) begin
            if (pos < sl && c != sframe_chars[8*pos +: 8]) sframe_ok = 1'b0;
            // data lags by the checksum and end frame width
            if (pos >= k + sl) take_data(pos - k - sl, win_char(k, c));
        end
        if (!b.last) begin
            for (j = WIN_DEPTH - 1; j > 0; j--) win[j] = win[j - 1];
            win[0] = c;
            if (pos + 1 >= MAX_REPLY_CHARS) too_long = 1'b1;
            else char_pos = pos + 1;
            return 1'b0;
        end
        total = pos + 1;
        if (too_long || !sframe_ok || total <= sl + el) begin
            r.verdict = VERDICT_BAD_FRAME;
        end else begin
            for (i = 0; i < el; i++) begin
                if (win_char(el - 1 - i, c) != eframe_chars[8*i +: 8]) r.verdict = VERDICT_BAD_FRAME;
            end
        end
        if (r.verdict == VERDICT_OK && crc_on_cfg) begin
            if (total - sl - el < 4) begin
                r.verdict = VERDICT_BAD_CKS;
            end else begin
                given     = 16'h0000;
                digits_ok = 1'b1;
                for (j = el + 3; j >= el; j--) begin
                    h = hex_of(win_char(j, c));
                    if (h >= 16) digits_ok = 1'b0;
                    given = {given[11:0], 4'(h)};
                end
                if (!digits_ok || given != run_cks) r.verdict = VERDICT_BAD_CKS;
            end
        end
        if (r.verdict == VERDICT_OK && id_digits != 2) r.verdict = VERDICT_NO_ID;
        if (r.verdict == VERDICT_OK && got_id != want_id) r.verdict = VERDICT_WRONG_ID;
        if (r.verdict == VERDICT_OK && want_status && stat_digits != 3) r.verdict = VERDICT_NO_STATUS;
        if (r.verdict inside {VERDICT_OK, VERDICT_WRONG_ID, VERDICT_NO_STATUS}) r.rid = got_id;
        if (r.verdict == VERDICT_OK && want_status) r.sval = 10'(stat_acc);
        r.err = (r.verdict == VERDICT_OK && r.sval != 10'd0);
        clear_reply();
        return 1'b1;
    endfunction

    function automatic void add_begin(input logic [7:0] id, input bit hs);
        t_stim_row row;
        row.kind  = ROW_BEAT;
        row.b     = '{CMD_BEGIN, id, hs, 8'($urandom_range(1, 255)), 1'($urandom)};
        row.fixed = 1'b0;
        row.r     = '{VERDICT_OK, 8'h00, 10'd0, 1'b0};
        script.push_back(row);
    endfunction

    function automatic void add_text(input string s);
        t_stim_row row;
        int i;
        for (i = 0; i < s.len(); i++) begin
            row.kind  = ROW_BEAT;
            row.b     = '{CMD_CHAR, 8'($urandom), 1'($urandom), s[i], i == s.len() - 1};
            row.fixed = 1'b0;
            row.r     = '{VERDICT_OK, 8'h00, 10'd0, 1'b0};
            script.push_back(row);
        end
    endfunction

    function automatic void add_cfg(input t_cfg_index idx, input logic [31:0] data);
        t_stim_row row;
        row.kind  = ROW_CFG;
        row.b     = '{CMD_BEGIN, 8'h00, 1'b0, 8'h01, 1'b0};
        row.idx   = idx;
        row.data  = data;
        row.fixed = 1'b0;
        row.r     = '{VERDICT_OK, 8'h00, 10'd0, 1'b0};
        script.push_back(row);
    endfunction

    // the last row's result is known by hand
    function automatic void known_result(input t_verdict v, input logic [7:0] rid,
                                         input logic [9:0] sval, input logic err);
        script[script.size() - 1].fixed = 1'b1;
        script[script.size() - 1].r     = '{v, rid, sval, err};
    endfunction

    task automatic put_beat(input t_beat b, input bit fixed, input t_reply_result fixed_res);
        t_reply_result r;
        bit has_res;
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_command     <= b.cmd;
        i_expected_id <= b.eid;
        i_has_status  <= b.hs;
        i_reply_char  <= b.ch;
        i_last_char   <= b.last;
        do @(posedge i_clk); while (o_in_stall);
        has_res = judge_beat(b, r);
        if (fixed) r = fixed_res;
        if (has_res) verdicts_due.push_back(r);
        beats_sent++;
    endtask

    // sender bursts with random gaps
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
        end
        burst_left--;
    endtask

    // drop valid and let the block drain before a register write
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_CHECK_CRC: begin
                crc_on_cfg = data[0];
            end
            CFG_START_CHARS: begin
                sframe_chars = data;
            end
            CFG_START_LEN: begin
                sframe_len = data[2:0];
            end
            CFG_END_CHARS: begin
                eframe_chars = data;
            end
            CFG_END_LEN: begin
                eframe_len = data[2:0];
            end
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic new_setting(input int phase);
        logic [31:0] sc, ec;
        logic [2:0] sl, el;
        logic crc;
        int i;
        crc = 1'($urandom);
        sl  = 3'($urandom_range(0, 4));
        el  = 3'($urandom_range(0, 4));
        for (i = 0; i < 4; i++) begin
            sc[8*i +: 8] = 8'($urandom_range(33, 126));
            ec[8*i +: 8] = 8'($urandom_range(33, 126));
        end
        case (phase)
            0: begin
                crc = 1'b1;
                sl  = 3'd4;
                el  = 3'd4;
            end
            1: begin
                crc = 1'b0;
                sl  = 3'd0;
                el  = 3'd0;
                sc  = 32'h0000_0000;
                ec  = 32'h0000_0000;
            end
            2: begin
                // lengths past the frame limit
                sl = 3'd7;
                el = 3'd5;
                sc = 32'hFFFF_FFFF;
                ec = 32'hFFFF_FFFF;
            end
            3: begin
                // a nul in the start frame never matches a reply char
                sl        = 3'd2;
                sc[15:8]  = 8'h00;
            end
            default: begin
            end
        endcase
        settle();
        write_reg(CFG_CHECK_CRC, 32'(crc));
        write_reg(CFG_START_CHARS, sc);
        write_reg(CFG_START_LEN, 32'(sl));
        write_reg(CFG_END_CHARS, ec);
        write_reg(CFG_END_LEN, 32'(el));
    endtask

    task automatic send_text(input logic [7:0] txt[$]);
        t_beat b;
        int i;
        for (i = 0; i < txt.size(); i++) begin
            pace();
            b = '{CMD_CHAR, 8'($urandom), 1'($urandom), txt[i], i == txt.size() - 1};
            put_beat(b, 1'b0, '{VERDICT_OK, 8'h00, 10'd0, 1'b0});
        end
    endtask

    // well-formed reply for the current setting, sometimes with one fault
    task automatic send_reply(input logic [7:0] id, input bit hs);
        logic [7:0] body[$];
        logic [7:0] txt[$];
        logic [15:0] cks;
        int i, n, fault;
        bit lc;
        if ($urandom_range(0, 9) == 0) id = 8'($urandom);
        lc = 1'($urandom);
        body.push_back(hex_char(id[7:4], lc));
        body.push_back(hex_char(id[3:0], lc));
        repeat (3) body.push_back(8'($urandom_range(1, 255)));
        if (hs || $urandom_range(0, 1) == 1) begin
            n = $urandom_range(0, 999);
            body.push_back(8'h30 + 8'(n / 100));
            body.push_back(8'h30 + 8'((n / 10) % 10));
            body.push_back(8'h30 + 8'(n % 10));
        end
        repeat ($urandom_range(0, 3)) body.push_back(8'($urandom_range(1, 255)));
        fault = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        if (fault == 6) begin
            if (long_replies < 2 && $urandom_range(0, 2) == 0) begin
                long_replies++;
                repeat (MAX_REPLY_CHARS + 5) body.push_back(8'($urandom_range(1, 255)));
            end else begin
                fault = 7;
            end
        end
        case (fault)
            1: body[1] = "g";
            2: body[0] = "z";
            3: if (body.size() > 6) body[6] = "x";
            default: ;
        endcase
        for (i = 0; i < eff_len(sframe_len); i++) begin
            txt.push_back((sframe_chars[8*i +: 8] == 8'h00) ? 8'h01 : sframe_chars[8*i +: 8]);
        end
        foreach (body[j]) txt.push_back(body[j]);
        if (crc_on_cfg) begin
            cks = CKS_SEED;
            foreach (body[j]) cks = mix16(cks, body[j]);
            if (fault == 4) cks = cks ^ (16'h0001 << $urandom_range(0, 15));
            lc = 1'($urandom);
            for (i = 3; i >= 0; i--) txt.push_back(hex_char(cks[4*i +: 4], lc));
        end
        for (i = 0; i < eff_len(eframe_len); i++) begin
            txt.push_back((eframe_chars[8*i +: 8] == 8'h00) ? 8'h01 : eframe_chars[8*i +: 8]);
        end
        if (fault == 5) begin
            n = $urandom_range(1, txt.size());
            while (txt.size() > n) void'(txt.pop_back());
        end
        if (fault == 7) txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(1, 255));
        send_text(txt);
    endtask

    // receiver stall pattern, with one long hold-off on request
    initial begin
        int mode, stretch;
        bit hold_done;
        i_out_stall = 1'b0;
        hold_done   = 1'b0;
        forever begin
            mode    = $urandom_range(0, 2);
            stretch = $urandom_range(20, 120);
            repeat (stretch) begin
                @(negedge i_clk);
                if (hold_req && !hold_done) begin
                    i_out_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                    hold_done = 1'b1;
                end
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 3) == 0);
                    default: i_out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_reply_result oldest;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdicts_due.size() == 0) begin
                flag_error($sformatf("result with none pending, verdict %0d", o_verdict));
            end else begin
                oldest = verdicts_due.pop_front();
                if (o_verdict !== oldest.verdict)
                    flag_error($sformatf("verdict %0d, want %0d", o_verdict, oldest.verdict));
                if (o_reply_id !== oldest.rid)
                    flag_error($sformatf("reply_id %h, want %h", o_reply_id, oldest.rid));
                if (o_status_value !== oldest.sval)
                    flag_error($sformatf("status %0d, want %0d", o_status_value, oldest.sval));
                if (o_status_error !== oldest.err)
                    flag_error($sformatf("status_error %b, want %b", o_status_error, oldest.err));
            end
        end
    end

    // ends the run when no channel moves a beat for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_framed_reply_checker: errors");
        $finish;
    end

    initial begin
        t_beat b;
        logic [7:0] txt[$];
        logic [7:0] cur_id;
        bit cur_hs;
        int goal, replies, phase, pick;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_command     = CMD_BEGIN;
        i_expected_id = 8'h00;
        i_has_status  = 1'b0;
        i_reply_char  = 8'h01;
        i_last_char   = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_CHECK_CRC;
        i_cfg_data    = 32'h0;
        hold_req      = 1'b0;
        mismatches    = 0;
        beats_sent    = 0;
        burst_left    = 0;
        long_replies  = 0;
        crc_on_cfg    = 1'b0;
        sframe_chars  = 32'h0;
        sframe_len    = 3'd0;
        eframe_chars  = 32'h0;
        eframe_len    = 3'd0;
        want_id       = 8'h00;
        want_status   = 1'b0;
        clear_reply();

        // one id digit right after reset, so no id is found
        add_text("5");
        known_result(VERDICT_NO_ID, 8'h00, 10'd0, 1'b0);
        add_begin(8'hFF, 1'b1);
        add_text("Ffxyz999");
        known_result(VERDICT_OK, 8'hFF, 10'd999, 1'b1);
        add_begin(8'hAB, 1'b1);
        add_text("AB");
        known_result(VERDICT_NO_STATUS, 8'hAB, 10'd0, 1'b0);
        // no begin: previous id and status setting still apply
        add_text("ac");
        known_result(VERDICT_WRONG_ID, 8'hAC, 10'd0, 1'b0);
        add_cfg(CFG_START_CHARS, 32'h0000_003C);
        add_cfg(CFG_START_LEN, 32'd1);
        add_cfg(CFG_END_CHARS, 32'h0000_003E);
        add_cfg(CFG_END_LEN, 32'd1);
        add_cfg(CFG_CHECK_CRC, 32'd1);
        add_text("<ABd744>");
        add_text("<1>");
        known_result(VERDICT_BAD_CKS, 8'h00, 10'd0, 1'b0);
        add_text(">");
        known_result(VERDICT_BAD_FRAME, 8'h00, 10'd0, 1'b0);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].kind == ROW_CFG) begin
                settle();
                write_reg(script[i].idx, script[i].data);
            end else begin
                put_beat(script[i].b, script[i].fixed, script[i].r);
            end
        end

        goal    = beats_sent + RANDOM_BEATS;
        replies = 0;
        phase   = 0;
        cur_id  = 8'hAB;
        cur_hs  = 1'b1;
        while (beats_sent < goal) begin
            if (replies % 12 == 0) begin
                new_setting(phase);
                phase++;
            end
            // fill the block once while the receiver holds off
            if (replies == 1) hold_req = 1'b1;
            pick = $urandom_range(0, 19);
            if (pick >= 3) begin
                cur_id = 8'($urandom);
                cur_hs = 1'($urandom);
                b = '{CMD_BEGIN, cur_id, cur_hs, 8'($urandom_range(1, 255)), 1'($urandom)};
                pace();
                put_beat(b, 1'b0, '{VERDICT_OK, 8'h00, 10'd0, 1'b0});
            end
            if ($urandom_range(0, 9) == 0) begin
                txt.delete();
                repeat ($urandom_range(1, 12)) txt.push_back(8'($urandom_range(1, 255)));
                send_text(txt);
            end else begin
                send_reply(cur_id, cur_hs);
            end
            replies++;
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_framed_reply_checker: clean");
        end else begin
            $display("tb_framed_reply_checker: errors");
        end
        $finish;
    end
endmodule
